[design/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, controller states and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Width of base, exponent, modulus and result.
  localparam int unsigned OPERAND_BITS = 63;
  // Width of the bit counter of one modular product.
  localparam int unsigned CNT_W = $clog2(OPERAND_BITS);
  // Width of the shift-and-add sum before reduction (below three moduli).
  localparam int unsigned SUM_W = OPERAND_BITS + 2;

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL_RES,
    ST_SQUARE,
    ST_DONE
  } mexp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new transaction
    logic setup_mul;   // start product result * base
    logic setup_sqr;   // start product base * base
    logic step;        // one shift-and-add step of the product
    logic wr_base;     // finished product goes to the base register
    logic wr_res;      // finished product goes to the result register
    logic shift_exp;   // drop the exponent bit just handled
    logic out_load;    // copy the result to the output register
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic exp_hi_zero;
    logic cnt_last;
  } mexp_status_t;

endpackage

`default_nettype wire

[design/mexp_dp.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand registers and a bit-serial shift-and-add modular product unit that
// handles one multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mexp_pkg::mexp_cmd_t    cmd_i,
  output mexp_pkg::mexp_status_t      status_o,
  input  wire mexp_pkg::operand_t     base_i,
  input  wire mexp_pkg::operand_t     exponent_i,
  input  wire mexp_pkg::operand_t     modulus_i,
  output mexp_pkg::operand_t          power_mod_o
);

  mexp_pkg::operand_t b_q, b_d;
  mexp_pkg::operand_t e_q, e_d;
  mexp_pkg::operand_t m_q, m_d;
  mexp_pkg::operand_t r_q, r_d;
  mexp_pkg::operand_t acc_q, acc_d;
  mexp_pkg::operand_t x_q, x_d;
  mexp_pkg::operand_t y_q, y_d;
  mexp_pkg::count_t   cnt_q, cnt_d;
  mexp_pkg::operand_t power_mod_q, power_mod_d;

  logic [mexp_pkg::SUM_W-1:0] sum_w;
  logic [mexp_pkg::SUM_W-1:0] mod1_w;
  logic [mexp_pkg::SUM_W-1:0] mod2_w;
  logic [mexp_pkg::SUM_W-1:0] red_w;
  mexp_pkg::operand_t         addend_w;
  mexp_pkg::operand_t         acc_step_w;

  // One step: acc = (2 * acc + (y bit ? x : 0)) mod m. With acc < m and
  // x <= m the sum stays below 3m, so the reduction is a choice between
  // subtracting nothing, m or 2m.
  always_comb begin
    addend_w = y_q[mexp_pkg::OPERAND_BITS-1] ? x_q : '0;
    sum_w    = {1'b0, acc_q, 1'b0} + {2'b00, addend_w};
    mod1_w   = {2'b00, m_q};
    mod2_w   = {1'b0, m_q, 1'b0};
    if (sum_w >= mod2_w) begin
      red_w = sum_w - mod2_w;
    end else if (sum_w >= mod1_w) begin
      red_w = sum_w - mod1_w;
    end else begin
      red_w = sum_w;
    end
    acc_step_w = red_w[mexp_pkg::OPERAND_BITS-1:0];
  end

  always_comb begin
    b_d         = b_q;
    e_d         = e_q;
    m_d         = m_q;
    r_d         = r_q;
    acc_d       = acc_q;
    x_d         = x_q;
    y_d         = y_q;
    cnt_d       = cnt_q;
    power_mod_d = power_mod_q;

    if (cmd_i.load) begin
      // The base is first reduced as a product 1 * base, with x = 1.
      b_d   = base_i;
      e_d   = exponent_i;
      m_d   = modulus_i;
      r_d   = (modulus_i > mexp_pkg::operand_t'(1)) ? mexp_pkg::operand_t'(1) : '0;
      acc_d = '0;
      x_d   = mexp_pkg::operand_t'(1);
      y_d   = base_i;
      cnt_d = '0;
    end
    if (cmd_i.step) begin
      acc_d = acc_step_w;
      y_d   = y_q << 1;
      cnt_d = cnt_q + mexp_pkg::count_t'(1);
    end
    if (cmd_i.wr_base) begin
      b_d = acc_step_w;
    end
    if (cmd_i.wr_res) begin
      r_d = acc_step_w;
    end
    if (cmd_i.shift_exp) begin
      e_d = e_q >> 1;
    end
    if (cmd_i.setup_mul) begin
      acc_d = '0;
      x_d   = r_q;
      y_d   = b_q;
      cnt_d = '0;
    end
    if (cmd_i.setup_sqr) begin
      acc_d = '0;
      x_d   = b_q;
      y_d   = b_q;
      cnt_d = '0;
    end
    if (cmd_i.out_load) begin
      power_mod_d = r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q         <= b_d;
    e_q         <= e_d;
    m_q         <= m_d;
    r_q         <= r_d;
    acc_q       <= acc_d;
    x_q         <= x_d;
    y_q         <= y_d;
    power_mod_q <= power_mod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign status_o.mod_zero    = (m_q == '0);
  assign status_o.exp_zero    = (e_q == '0);
  assign status_o.exp_lsb     = e_q[0];
  assign status_o.exp_hi_zero = (e_q[mexp_pkg::OPERAND_BITS-1:1] == '0);
  assign status_o.cnt_last    = (cnt_q == mexp_pkg::count_t'(mexp_pkg::OPERAND_BITS - 1));
  assign power_mod_o          = power_mod_q;

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && (m_q != '0)) |=> (acc_q < m_q))
    else $error("product accumulator left the modulus range");

  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_res && (m_q != '0)) |=> (r_q < m_q))
    else $error("running result not reduced");

  a_unit_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && (m_q == mexp_pkg::operand_t'(1))) |=> (power_mod_q == '0))
    else $error("modulus one must give zero");

endmodule

`default_nettype wire

[design/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, the per-bit multiply and square products and
// the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  input  wire mexp_pkg::mexp_status_t status_i,
  output mexp_pkg::mexp_cmd_t         cmd_o
);

  mexp_pkg::mexp_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free_w;
  logic                  accept_w;

  assign out_free_w = !out_valid_q || !out_stall_i;
  assign accept_w   = in_valid_i && (state_q == mexp_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (status_i.mod_zero) begin
          state_d = mexp_pkg::ST_DONE;
        end else if (status_i.cnt_last) begin
          state_d = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (status_i.exp_zero) begin
          state_d = mexp_pkg::ST_DONE;
        end else if (status_i.exp_lsb) begin
          state_d = mexp_pkg::ST_MUL_RES;
        end else begin
          state_d = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_MUL_RES: begin
        if (status_i.cnt_last) begin
          // The squaring after the top exponent bit is never used.
          state_d = status_i.exp_hi_zero ? mexp_pkg::ST_CHECK : mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_SQUARE: begin
        if (status_i.cnt_last) begin
          state_d = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (out_free_w) begin
          state_d = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      mexp_pkg::ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      mexp_pkg::ST_REDUCE: begin
        if (!status_i.mod_zero) begin
          cmd_o.step    = 1'b1;
          cmd_o.wr_base = status_i.cnt_last;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (!status_i.exp_zero) begin
          cmd_o.setup_mul = status_i.exp_lsb;
          cmd_o.setup_sqr = !status_i.exp_lsb;
        end
      end
      mexp_pkg::ST_MUL_RES: begin
        cmd_o.step = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.wr_res    = 1'b1;
          cmd_o.shift_exp = status_i.exp_hi_zero;
          cmd_o.setup_sqr = !status_i.exp_hi_zero;
        end
      end
      mexp_pkg::ST_SQUARE: begin
        cmd_o.step = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.wr_base   = 1'b1;
          cmd_o.shift_exp = 1'b1;
        end
      end
      mexp_pkg::ST_DONE: begin
        cmd_o.out_load = out_free_w;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != mexp_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |=> (state_q == mexp_pkg::ST_REDUCE))
    else $error("accepted transaction did not start base reduction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free_w)
    else $error("output register overwritten while a result waits");

  a_single_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.setup_mul && cmd_o.setup_sqr))
    else $error("both products started at once");

endmodule

`default_nettype wire

[design/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation
// Returns base ** exponent mod modulus by the right-to-left binary method,
// with every product formed by a bit-serial shift-and-add modular product.
// ----------------------------------------------------------------------------
//
//   channel  handshake                 payload
//   -------  ------------------------  ---------------------------------
//   in       in_valid_i / in_stall_o   base_i, exponent_i, modulus_i
//   out      out_valid_o / out_stall_i power_mod_o
//
// One transaction runs through acceptance, then base reduction, then for
// every exponent bit up to the top set bit a decision followed by a square
// for a clear bit, by a multiply and a square for a set bit and by a
// multiply only for the top bit, then a final decision and the copy into
// the output register. The pace is set by the single shift-and-add product
// unit, one multiplier bit a cycle. Reset clears the controller and the
// product bit counter only. A new transaction is taken while the previous
// result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mexp_pkg::operand_t base_i,
  input  wire mexp_pkg::operand_t exponent_i,
  input  wire mexp_pkg::operand_t modulus_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mexp_pkg::operand_t      power_mod_o
);

  mexp_pkg::mexp_cmd_t    cmd_w;
  mexp_pkg::mexp_status_t status_w;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_w),
    .cmd_o       (cmd_w)
  );

  mexp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_w),
    .status_o    (status_w),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .modulus_i   (modulus_i),
    .power_mod_o (power_mod_o)
  );

endmodule

`default_nettype wire
